/* sv/incremental_pan_tilt_servo_macros.svh */
// assertion macros for the pan/tilt servo block
// expects clk_i and rst_ni in the scope of the module that uses them

`ifndef INCREMENTAL_PAN_TILT_SERVO_MACROS_SVH
`define INCREMENTAL_PAN_TILT_SERVO_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define IPTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define IPTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ipts_pkg.sv */
// shared constants, types and register codes for the pan/tilt servo block
// used by ipts_mul and incremental_pan_tilt_servo; no dependencies

`timescale 1ns / 1ps

package ipts_pkg;

  // build-time configuration
  localparam int COORD_BITS      = 10;
  localparam int ANGLE_FRAC_BITS = 16;

  // fixed field widths
  localparam int CENTER_W   = 10;
  localparam int DZ_W       = 10;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 16;
  localparam int COMPARE_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // angle: whole degrees need 8 bits for 0..180
  localparam int ANGLE_W = 8 + ANGLE_FRAC_BITS;

  // error magnitude and step widths
  localparam int RAW_STEP_W  = COORD_BITS + GAIN_W;
  localparam int STEP_WIDE_W = RAW_STEP_W + ANGLE_FRAC_BITS;
  localparam int STEP_W      = COORD_BITS + ANGLE_FRAC_BITS;
  localparam int SUM_W       = STEP_W + 2;
  localparam int CMP_W       = (COORD_BITS > DZ_W) ? COORD_BITS : DZ_W;

  // compare scaling: angle * span >> frac, then divide by 180
  localparam int DIV_C       = 180;
  localparam int SCALED_W    = 8 + COMPARE_W;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 25;

  // shared multiplier operand widths
  localparam int MUL_A_W = (ANGLE_W > SCALED_W) ? ANGLE_W : SCALED_W;
  localparam int MUL_B_W = RECIP_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [CENTER_W-1:0]    center_t;
  typedef logic [DZ_W-1:0]        dz_t;
  typedef logic [GAIN_W-1:0]      gain_t;
  typedef logic [COMPARE_W-1:0]   compare_t;
  typedef logic [CMP_W-1:0]       cmp_t;
  typedef logic [ANGLE_W-1:0]     angle_t;
  typedef logic [RAW_STEP_W-1:0]  raw_step_t;
  typedef logic [STEP_WIDE_W-1:0] step_wide_t;
  typedef logic [STEP_W-1:0]      step_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [COORD_BITS:0] err_t;
  typedef logic [SCALED_W-1:0]    scaled_t;
  typedef logic [COMPARE_W-1:0]   quot_t;
  typedef logic [MUL_A_W-1:0]     mul_a_t;
  typedef logic [MUL_B_W-1:0]     mul_b_t;
  typedef logic [PROD_W-1:0]      prod_t;

  localparam angle_t ANGLE_MAX = angle_t'(180) << ANGLE_FRAC_BITS;
  localparam angle_t ANGLE_MID = angle_t'(90) << ANGLE_FRAC_BITS;

  // floor(2^32 / 180), low by at most one in the quotient for any scaled value
  localparam mul_b_t RECIP = mul_b_t'((64'd1 << RECIP_SHIFT) / DIV_C);

  // register reset values
  localparam center_t  RST_CENTER_X = center_t'(160);
  localparam center_t  RST_CENTER_Y = center_t'(120);
  localparam dz_t      RST_DEAD_ZONE = dz_t'(15);
  localparam gain_t    RST_GAIN = gain_t'(3277);
  localparam compare_t RST_CMP_MIN = compare_t'(500);
  localparam compare_t RST_CMP_MAX = compare_t'(2500);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_DEAD_ZONE   = 3'd2,
    REG_STEP_GAIN   = 3'd3,
    REG_COMPARE_MIN = 3'd4,
    REG_COMPARE_MAX = 3'd5
  } reg_idx_e;

  // request to the shared multiplier
  typedef struct packed {
    logic   en;
    mul_a_t a;
    mul_b_t b;
  } mul_req_t;

endpackage

/* sv/incremental_pan_tilt_servo.sv */
// Pan/tilt servo aiming block. Each transaction on the input channel is one
// coordinate pair; each yields exactly one output transaction with the PWM
// compare values for both servos and the aimed flag. The result is loaded
// into the output register in the same cycle that the input becomes ready
// again, and a new item is taken only after the last one is finished.
// The pace is set by the single shared multiplier, which runs eight
// products per item (one step product per axis, then angle*span, a
// reciprocal multiply and a back-multiply for the divide by 180 per axis).
// A result waiting on a stalled output holds the next item in its final
// step. Configuration writes are taken at any time but belong in idle time.
// depends on ipts_pkg, ipts_mul and incremental_pan_tilt_servo_macros.svh

`timescale 1ns / 1ps

module incremental_pan_tilt_servo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ipts_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ipts_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ipts_pkg::COORD_BITS-1:0]     coord_x_i,
  input  logic [ipts_pkg::COORD_BITS-1:0]     coord_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ipts_pkg::COMPARE_W-1:0]      pan_compare_o,
  output logic [ipts_pkg::COMPARE_W-1:0]      tilt_compare_o,
  output logic                                aimed_o
);

  `include "incremental_pan_tilt_servo_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_STEP,
    S_ACC,
    S_SCALE,
    S_RECIP,
    S_BACK,
    S_FIX,
    S_OUT
  } state_e;

  // configuration registers
  ipts_pkg::center_t  center_x_q, center_y_q;
  ipts_pkg::dz_t      dead_zone_q;
  ipts_pkg::gain_t    step_gain_q;
  ipts_pkg::compare_t compare_min_q, compare_max_q;

  // sequencer state and working registers
  state_e              state_q;
  logic                axis_q;
  ipts_pkg::coord_t    coord_x_q, coord_y_q;
  ipts_pkg::coord_t    mag_x_q, mag_y_q;
  logic                neg_x_q, neg_y_q;
  logic                aimed_q;
  ipts_pkg::angle_t    pan_angle_q, tilt_angle_q;
  ipts_pkg::scaled_t   scaled_q;
  ipts_pkg::quot_t     quot_q;
  ipts_pkg::compare_t  pan_res_q;

  // output register
  logic                out_valid_q;
  ipts_pkg::compare_t  pan_compare_q, tilt_compare_q;
  logic                out_aimed_q;

  // combinational helpers
  ipts_pkg::err_t      err_x, err_y;
  ipts_pkg::coord_t    mag_x, mag_y;
  logic                aimed;
  ipts_pkg::compare_t  span;
  ipts_pkg::angle_t    angle_sel;
  ipts_pkg::coord_t    mag_sel;
  logic                neg_sel;
  ipts_pkg::step_wide_t step_wide;
  ipts_pkg::step_t     step_mag;
  ipts_pkg::sum_t      angle_s, step_s, angle_sum;
  ipts_pkg::angle_t    angle_new;
  ipts_pkg::scaled_t   back_prod, rem;
  ipts_pkg::quot_t     quot_fixed;
  ipts_pkg::compare_t  compare_val;
  ipts_pkg::mul_req_t  mul_req;
  ipts_pkg::prod_t     prod;

  // configuration write port, out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= ipts_pkg::RST_CENTER_X;
      center_y_q    <= ipts_pkg::RST_CENTER_Y;
      dead_zone_q   <= ipts_pkg::RST_DEAD_ZONE;
      step_gain_q   <= ipts_pkg::RST_GAIN;
      compare_min_q <= ipts_pkg::RST_CMP_MIN;
      compare_max_q <= ipts_pkg::RST_CMP_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ipts_pkg::REG_CENTER_X:    center_x_q    <= ipts_pkg::center_t'(cfg_data_i);
        ipts_pkg::REG_CENTER_Y:    center_y_q    <= ipts_pkg::center_t'(cfg_data_i);
        ipts_pkg::REG_DEAD_ZONE:   dead_zone_q   <= ipts_pkg::dz_t'(cfg_data_i);
        ipts_pkg::REG_STEP_GAIN:   step_gain_q   <= ipts_pkg::gain_t'(cfg_data_i);
        ipts_pkg::REG_COMPARE_MIN: compare_min_q <= ipts_pkg::compare_t'(cfg_data_i);
        ipts_pkg::REG_COMPARE_MAX: compare_max_q <= ipts_pkg::compare_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // signed errors from center, magnitudes and dead zone test
  always_comb begin
    err_x = $signed({1'b0, coord_x_q}) - $signed({1'b0, ipts_pkg::coord_t'(center_x_q)});
    err_y = $signed({1'b0, coord_y_q}) - $signed({1'b0, ipts_pkg::coord_t'(center_y_q)});
    mag_x = err_x[ipts_pkg::COORD_BITS] ? ipts_pkg::coord_t'(-err_x)
                                        : ipts_pkg::coord_t'(err_x);
    mag_y = err_y[ipts_pkg::COORD_BITS] ? ipts_pkg::coord_t'(-err_y)
                                        : ipts_pkg::coord_t'(err_y);
    aimed = (ipts_pkg::cmp_t'(mag_x) < ipts_pkg::cmp_t'(dead_zone_q)) &&
            (ipts_pkg::cmp_t'(mag_y) < ipts_pkg::cmp_t'(dead_zone_q));
  end

  // negative span counts as zero
  assign span = (compare_max_q > compare_min_q) ? (compare_max_q - compare_min_q) : '0;

  // per-axis operand selection
  assign angle_sel = axis_q ? tilt_angle_q : pan_angle_q;
  assign mag_sel   = axis_q ? mag_y_q : mag_x_q;
  assign neg_sel   = axis_q ? neg_y_q : neg_x_q;

  // angle update: rescale Q0.16 gain product to angle units, add, clamp
  always_comb begin
    step_wide = ipts_pkg::step_wide_t'(ipts_pkg::raw_step_t'(prod)) << ipts_pkg::ANGLE_FRAC_BITS;
    step_mag  = ipts_pkg::step_t'(step_wide >> ipts_pkg::GAIN_FRAC);
    angle_s   = ipts_pkg::sum_t'(angle_sel);
    step_s    = ipts_pkg::sum_t'(step_mag);
    angle_sum = neg_sel ? (angle_s - step_s) : (angle_s + step_s);
    priority if (angle_sum < ipts_pkg::sum_t'(0)) begin
      angle_new = '0;
    end else if (angle_sum > ipts_pkg::sum_t'(ipts_pkg::ANGLE_MAX)) begin
      angle_new = ipts_pkg::ANGLE_MAX;
    end else begin
      angle_new = ipts_pkg::angle_t'(angle_sum);
    end
  end

  // divide-by-180 correction: estimate is low by at most one
  always_comb begin
    back_prod   = ipts_pkg::scaled_t'(prod);
    rem         = scaled_q - back_prod;
    quot_fixed  = quot_q + ipts_pkg::quot_t'(rem >= ipts_pkg::scaled_t'(ipts_pkg::DIV_C));
    compare_val = compare_min_q + quot_fixed;
  end

  // shared multiplier operand mux
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      S_STEP: begin
        mul_req.en = 1'b1;
        mul_req.a  = ipts_pkg::mul_a_t'(mag_sel);
        mul_req.b  = ipts_pkg::mul_b_t'(step_gain_q);
      end
      S_SCALE: begin
        mul_req.en = 1'b1;
        mul_req.a  = ipts_pkg::mul_a_t'(angle_sel);
        mul_req.b  = ipts_pkg::mul_b_t'(span);
      end
      S_RECIP: begin
        mul_req.en = 1'b1;
        mul_req.a  = ipts_pkg::mul_a_t'(ipts_pkg::scaled_t'(prod >> ipts_pkg::ANGLE_FRAC_BITS));
        mul_req.b  = ipts_pkg::RECIP;
      end
      S_BACK: begin
        mul_req.en = 1'b1;
        mul_req.a  = ipts_pkg::mul_a_t'(ipts_pkg::quot_t'(prod >> ipts_pkg::RECIP_SHIFT));
        mul_req.b  = ipts_pkg::mul_b_t'(ipts_pkg::DIV_C);
      end
      default: mul_req = '0;
    endcase
  end

  ipts_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // sequencer, angle state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      axis_q         <= 1'b0;
      coord_x_q      <= '0;
      coord_y_q      <= '0;
      mag_x_q        <= '0;
      mag_y_q        <= '0;
      neg_x_q        <= 1'b0;
      neg_y_q        <= 1'b0;
      aimed_q        <= 1'b0;
      pan_angle_q    <= ipts_pkg::ANGLE_MID;
      tilt_angle_q   <= ipts_pkg::ANGLE_MID;
      scaled_q       <= '0;
      quot_q         <= '0;
      pan_res_q      <= '0;
      out_valid_q    <= 1'b0;
      pan_compare_q  <= '0;
      tilt_compare_q <= '0;
      out_aimed_q    <= 1'b0;
    end else begin
      // output transaction completes
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            coord_x_q <= coord_x_i;
            coord_y_q <= coord_y_i;
            state_q   <= S_ERR;
          end
        end
        S_ERR: begin
          mag_x_q <= mag_x;
          mag_y_q <= mag_y;
          neg_x_q <= err_x[ipts_pkg::COORD_BITS];
          neg_y_q <= err_y[ipts_pkg::COORD_BITS];
          aimed_q <= aimed;
          axis_q  <= 1'b0;
          state_q <= S_STEP;
        end
        S_STEP: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (!aimed_q) begin
            if (axis_q) begin
              tilt_angle_q <= angle_new;
            end else begin
              pan_angle_q <= angle_new;
            end
          end
          axis_q  <= ~axis_q;
          state_q <= axis_q ? S_SCALE : S_STEP;
        end
        S_SCALE: begin
          state_q <= S_RECIP;
        end
        S_RECIP: begin
          scaled_q <= ipts_pkg::scaled_t'(prod >> ipts_pkg::ANGLE_FRAC_BITS);
          state_q  <= S_BACK;
        end
        S_BACK: begin
          quot_q  <= ipts_pkg::quot_t'(prod >> ipts_pkg::RECIP_SHIFT);
          state_q <= S_FIX;
        end
        S_FIX: begin
          if (axis_q) begin
            state_q <= S_OUT;
          end else begin
            pan_res_q <= compare_val;
            axis_q    <= 1'b1;
            state_q   <= S_SCALE;
          end
        end
        S_OUT: begin
          // tilt value is still on the correction path, prod holds its back-product
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            pan_compare_q  <= pan_res_q;
            tilt_compare_q <= compare_val;
            out_aimed_q    <= aimed_q;
            axis_q         <= 1'b0;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign pan_compare_o  = pan_compare_q;
  assign tilt_compare_o = tilt_compare_q;
  assign aimed_o        = out_aimed_q;

  // angles never leave 0..180 degrees
  `IPTS_ASSERT_IMP(a_angle_range, 1'b1, (pan_angle_q <= ipts_pkg::ANGLE_MAX) && (tilt_angle_q <= ipts_pkg::ANGLE_MAX), "angle above 180 degrees")
  // an aimed item leaves both angles untouched
  `IPTS_ASSERT_NXT(a_aimed_hold, (state_q == S_ACC) && aimed_q, $stable(pan_angle_q) && $stable(tilt_angle_q), "angle moved on aimed item")
  // reciprocal estimate is at most one below the true quotient
  `IPTS_ASSERT_IMP(a_quot_fix, (state_q == S_FIX) || (state_q == S_OUT), rem < ipts_pkg::scaled_t'(2 * ipts_pkg::DIV_C), "divide estimate off by more than one")
  // finishing an item presents a result and frees the input
  `IPTS_ASSERT_NXT(a_out_load, (state_q == S_OUT) && (!out_valid_q || out_ready_i), out_valid_q && in_ready_o, "result not presented")

endmodule

/* sv/ipts_mul.sv */
// shared multiplier with registered product for the pan/tilt servo block
// depends on ipts_pkg

`timescale 1ns / 1ps

module ipts_mul (
  input  logic              clk_i,
  input  ipts_pkg::mul_req_t req_i,
  output ipts_pkg::prod_t   prod_o
);

  ipts_pkg::prod_t prod_q;

  // product register, loaded only when a step asks for it
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= ipts_pkg::prod_t'(req_i.a) * ipts_pkg::prod_t'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule
